FILE: rtl/core/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared sizes, codes and record types of the service provider table.
// ----------------------------------------------------------------------------
package spt_pkg;

  // Table and batch sizes
  localparam int unsigned SERVICES  = 64;
  localparam int unsigned KERNELS   = 4;
  localparam int unsigned MODULES   = 32;
  localparam int unsigned MAX_BATCH = 16;

  // Derived widths
  localparam int unsigned SID_W  = (SERVICES > 1) ? $clog2(SERVICES) : 1;
  localparam int unsigned KER_W  = (KERNELS > 1) ? $clog2(KERNELS) : 1;
  localparam int unsigned MOD_W  = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int unsigned BIDX_W = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_BATCH + 1);
  localparam int unsigned ENT_W  = KER_W + MOD_W;

  typedef enum logic [1:0] {
    CMD_REG    = 2'd0,
    CMD_UNREG  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_KERNEL_BAD  = 3'd1,
    ST_MODULE_BAD  = 3'd2,
    ST_ID_BAD      = 3'd3,
    ST_TAKEN       = 3'd4,
    ST_NOT_OWNER   = 3'd5,
    ST_TOO_LONG    = 3'd6
  } status_e;

  // One accepted item, as held for evaluation
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] sid;
    logic [7:0] kid;
    logic [7:0] mid;
    logic       no_ids;
  } item_t;

  // One table entry as read back
  typedef struct packed {
    logic             present;
    logic [KER_W-1:0] kernel;
    logic [MOD_W-1:0] module_id;
  } entry_t;

  // Open batch bookkeeping
  typedef struct packed {
    logic             active;
    logic [CNT_W-1:0] count;
    status_e          err;
    logic [KER_W-1:0] kernel;
    logic [MOD_W-1:0] module_id;
  } batch_t;

  // Check unit verdict
  typedef struct packed {
    batch_t  next;
    logic    store;
    status_e look_status;
  } chk_res_t;

endpackage

FILE: rtl/core/spt_ram.sv
// ----------------------------------------------------------------------------
// spt_ram
// Generic single-port RAM, one address a cycle, registered read-before-write.
// ----------------------------------------------------------------------------
module spt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read the addressed word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/spt_check.sv
// ----------------------------------------------------------------------------
// spt_check
// Check unit: opens a batch, runs provider range checks and the per-id
// check of one item against its table entry, and advances the batch record.
// ----------------------------------------------------------------------------
module spt_check (
  input  spt_pkg::item_t    item_i,
  input  spt_pkg::entry_t   entry_i,
  input  spt_pkg::batch_t   batch_i,
  output spt_pkg::chk_res_t res_o
);
  import spt_pkg::*;

  logic   sid_ok;
  logic   kid_ok;
  logic   mid_ok;
  logic   owner;
  batch_t nxt;
  logic   store;

  // Range compares against the table sizes
  assign sid_ok = {1'b0, item_i.sid} < 9'(SERVICES);
  assign kid_ok = {1'b0, item_i.kid} < 9'(KERNELS);
  assign mid_ok = {1'b0, item_i.mid} < 9'(MODULES);

  always_comb begin
    nxt   = batch_i;
    store = 1'b0;

    // Open a batch: take the provider and check its range
    if (!batch_i.active) begin
      nxt.active    = 1'b1;
      nxt.count     = '0;
      nxt.kernel    = item_i.kid[KER_W-1:0];
      nxt.module_id = item_i.mid[MOD_W-1:0];
      if (!kid_ok) begin
        nxt.err = ST_KERNEL_BAD;
      end else if (!mid_ok) begin
        nxt.err = ST_MODULE_BAD;
      end else begin
        nxt.err = ST_OK;
      end
    end

    owner = entry_i.present && (entry_i.kernel == nxt.kernel) &&
            (entry_i.module_id == nxt.module_id);

    // Per-id check, first failure wins, overflow overrides
    if (!item_i.no_ids) begin
      if (nxt.count >= CNT_W'(MAX_BATCH)) begin
        nxt.err = ST_TOO_LONG;
      end else if (nxt.err == ST_OK) begin
        if (!sid_ok) begin
          nxt.err = ST_ID_BAD;
        end else if (item_i.cmd == CMD_REG) begin
          if (entry_i.present) begin
            nxt.err = ST_TAKEN;
          end
        end else if (!owner) begin
          nxt.err = ST_NOT_OWNER;
        end
        if (nxt.err == ST_OK) begin
          store     = 1'b1;
          nxt.count = nxt.count + CNT_W'(1);
        end
      end
    end

    res_o.next        = nxt;
    res_o.store       = store;
    res_o.look_status = sid_ok ? ST_OK : ST_ID_BAD;
  end

endmodule

FILE: rtl/core/service_provider_table.sv
// ----------------------------------------------------------------------------
// service_provider_table
// Maps service numbers to providers; batched register and unregister with
// all-or-nothing commit, and single-entry lookup.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | beat contents
//  in      | input     | in_valid_i / in_stall_o  | command, ids, last, no_ids
//  out     | output    | out_valid_o / out_stall_i | status, provider fields
//
//  A lookup or a batch item is accepted with the table read, then evaluated
//  in the shared check unit. A clean last item with buffered ids then walks
//  the buffer through the table RAM port to commit, and loads the result.
//  Reset clears the per-entry present flags at once; no clearing pass.
//  A result waits in the output register; while it is stalled a pending
//  result holds the sequencer and the input stalls.
// ----------------------------------------------------------------------------
module service_provider_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] in_command_i,
  input  logic [7:0] in_service_id_i,
  input  logic [7:0] in_kernel_id_i,
  input  logic [7:0] in_module_id_i,
  input  logic       in_last_i,
  input  logic       in_no_ids_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] out_status_o,
  output logic       out_provider_present_o,
  output logic [7:0] out_provider_kernel_o,
  output logic [7:0] out_provider_module_o
);
  import spt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  typedef struct packed {
    status_e    status;
    logic       present;
    logic [7:0] kernel;
    logic [7:0] module_id;
  } res_t;

  state_e              state_q, state_d;
  batch_t              batch_q, batch_d;
  logic [BIDX_W-1:0]   cidx_q, cidx_d;
  logic [SERVICES-1:0] present_q;
  logic                out_valid_q, out_valid_d;

  item_t               item_q;
  logic                last_q;
  logic                present_rd_q;
  res_t                res_q, out_q;
  logic [SID_W-1:0]    batch_ids_q [MAX_BATCH];

  logic                in_acc;
  logic                in_sid_ok;
  logic                out_free;
  logic                out_load;
  logic                out_from_eval;
  logic                res_save;
  logic                commit_we;
  logic                commit_last;
  logic [SID_W-1:0]    commit_sid;
  logic [SID_W-1:0]    ram_addr;
  logic [ENT_W-1:0]    ram_rdata;
  entry_t              entry;
  chk_res_t            chk;
  res_t                res_d;

  // Input beat handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_sid_ok  = {1'b0, in_service_id_i} < 9'(SERVICES);

  // Table RAM: read on accept, write during commit
  assign commit_sid = batch_ids_q[cidx_q];
  assign commit_we  = (state_q == S_COMMIT);
  assign ram_addr   = commit_we ? commit_sid : in_service_id_i[SID_W-1:0];

  spt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SERVICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (commit_we),
    .addr_i  (ram_addr),
    .wdata_i ({batch_q.kernel, batch_q.module_id}),
    .rdata_o (ram_rdata)
  );

  assign entry.present   = present_rd_q;
  assign entry.kernel    = ram_rdata[ENT_W-1:MOD_W];
  assign entry.module_id = ram_rdata[MOD_W-1:0];

  spt_check u_check (
    .item_i  (item_q),
    .entry_i (entry),
    .batch_i (batch_q),
    .res_o   (chk)
  );

  // Form the result of the item under evaluation
  always_comb begin
    res_d = '0;
    if (item_q.cmd == CMD_LOOKUP) begin
      res_d.status  = chk.look_status;
      res_d.present = entry.present;
      if (entry.present) begin
        res_d.kernel    = 8'(entry.kernel);
        res_d.module_id = 8'(entry.module_id);
      end
    end else begin
      res_d.status = chk.next.err;
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit_last = (CNT_W'(cidx_q) + CNT_W'(1)) == batch_q.count;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    batch_d       = batch_q;
    cidx_d        = cidx_q;
    out_load      = 1'b0;
    out_from_eval = 1'b0;
    res_save      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (cmd_e'(in_command_i) != CMD_NONE)) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (item_q.cmd == CMD_LOOKUP) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_from_eval = 1'b1;
            state_d       = S_IDLE;
          end else begin
            res_save = 1'b1;
            state_d  = S_DONE;
          end
        end else if (!last_q) begin
          batch_d = chk.next;
          state_d = S_IDLE;
        end else if ((chk.next.err == ST_OK) && (chk.next.count != '0)) begin
          batch_d  = chk.next;
          cidx_d   = '0;
          res_save = 1'b1;
          state_d  = S_COMMIT;
        end else if (out_free) begin
          batch_d       = '0;
          out_load      = 1'b1;
          out_from_eval = 1'b1;
          state_d       = S_IDLE;
        end else begin
          batch_d  = chk.next;
          res_save = 1'b1;
          state_d  = S_DONE;
        end
      end
      S_COMMIT: begin
        cidx_d = cidx_q + BIDX_W'(1);
        if (commit_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (item_q.cmd != CMD_LOOKUP) begin
            batch_d = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output beat valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      batch_q     <= '0;
      cidx_q      <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      batch_q     <= batch_d;
      cidx_q      <= cidx_d;
      out_valid_q <= out_valid_d;
      if (commit_we) begin
        present_q[commit_sid] <= (item_q.cmd == CMD_REG);
      end
    end
  end

  // Payload: held item, read-back flag, buffered ids and results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.cmd    <= cmd_e'(in_command_i);
      item_q.sid    <= in_service_id_i;
      item_q.kid    <= in_kernel_id_i;
      item_q.mid    <= in_module_id_i;
      item_q.no_ids <= in_no_ids_i;
      last_q        <= in_last_i;
      present_rd_q  <= in_sid_ok ? present_q[in_service_id_i[SID_W-1:0]] : 1'b0;
    end
    if ((state_q == S_EVAL) && (item_q.cmd != CMD_LOOKUP) && chk.store) begin
      batch_ids_q[batch_q.active ? batch_q.count[BIDX_W-1:0] : '0] <=
        item_q.sid[SID_W-1:0];
    end
    if (res_save) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= out_from_eval ? res_d : res_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_status_o           = out_q.status;
  assign out_provider_present_o = out_q.present;
  assign out_provider_kernel_o  = out_q.kernel;
  assign out_provider_module_o  = out_q.module_id;

  // Commit only runs on a clean batch
  a_commit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> (batch_q.err == ST_OK))
    else $error("commit on a failed batch");

  // Buffered count stays within the buffer
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch_q.count <= CNT_W'(MAX_BATCH))
    else $error("batch count beyond buffer");

  // A result is loaded only into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("pending result overwritten");

  // An accepted lookup is evaluated in the next cycle
  a_lookup_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_e'(in_command_i) == CMD_LOOKUP)) |=> (state_q == S_EVAL))
    else $error("lookup not evaluated");

endmodule

FILE: tb/service_provider_table_tb.sv
// ----------------------------------------------------------------------------
// service_provider_table_tb
// Self-checking bench for the service provider table. A short directed run
// walks every status code but ST_TOO_LONG, lookups inside a batch, empty and
// mixed batches. A random run follows: mostly well-formed register and
// unregister batches built from the live table contents, lookups, and some raw
// noise beats, under four sender and receiver idling phases. A scoreboard
// class keeps its own table copy, predicts each reply, checks them in order.
// ----------------------------------------------------------------------------
module service_provider_table_tb;
  import spt_pkg::*;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned END_CYCLES  = 40;

  // Scoreboard: shadow table, open batch, and the replies still owed
  class provider_checker;
    typedef struct {
      status_e    status;
      logic       present;
      logic [7:0] kernel;
      logic [7:0] mod_id;
    } reply_t;

    bit             owned        [SERVICES];
    bit [7:0]       owner_kernel [SERVICES];
    bit [7:0]       owner_module [SERVICES];
    bit             open;
    status_e        batch_status;
    bit [7:0]       batch_kernel;
    bit [7:0]       batch_module;
    bit [SID_W-1:0] batch_ids [$];
    reply_t         expected_replies [$];
    int unsigned    fails;

    // Apply one accepted input beat and queue the reply it causes
    function void note_item(cmd_e cmd, bit [7:0] sid, bit [7:0] kid, bit [7:0] mid,
                            bit last, bit no_ids);
      reply_t rep;
      rep = '{ST_OK, 1'b0, 8'd0, 8'd0};
      if (cmd == CMD_NONE) return;
      if (cmd == CMD_LOOKUP) begin
        if (sid >= SERVICES) begin
          rep.status = ST_ID_BAD;
        end else if (owned[sid[SID_W-1:0]]) begin
          rep.present = 1'b1;
          rep.kernel  = owner_kernel[sid[SID_W-1:0]];
          rep.mod_id  = owner_module[sid[SID_W-1:0]];
        end
        expected_replies.push_back(rep);
        return;
      end
      // Open a batch: latch provider, check its range first
      if (!open) begin
        open = 1'b1;
        batch_ids.delete();
        batch_status = ST_OK;
        batch_kernel = kid;
        batch_module = mid;
        if (kid >= KERNELS) batch_status = ST_KERNEL_BAD;
        else if (mid >= MODULES) batch_status = ST_MODULE_BAD;
      end
      // Per-id checks; keep the first failure, overflow overrides all
      if (!no_ids) begin
        if (batch_ids.size() >= MAX_BATCH) begin
          batch_status = ST_TOO_LONG;
        end else if (batch_status == ST_OK) begin
          if (sid >= SERVICES) begin
            batch_status = ST_ID_BAD;
          end else if (cmd == CMD_REG && owned[sid[SID_W-1:0]]) begin
            batch_status = ST_TAKEN;
          end else if (cmd == CMD_UNREG && !(owned[sid[SID_W-1:0]] &&
                       owner_kernel[sid[SID_W-1:0]] == batch_kernel &&
                       owner_module[sid[SID_W-1:0]] == batch_module)) begin
            batch_status = ST_NOT_OWNER;
          end else begin
            batch_ids.push_back(sid[SID_W-1:0]);
          end
        end
      end
      if (!last) return;
      // Commit all or nothing under the closing beat's command
      if (batch_status == ST_OK) begin
        foreach (batch_ids[j]) begin
          owned[batch_ids[j]]        = (cmd == CMD_REG);
          owner_kernel[batch_ids[j]] = (cmd == CMD_REG) ? batch_kernel : 8'd0;
          owner_module[batch_ids[j]] = (cmd == CMD_REG) ? batch_module : 8'd0;
        end
      end
      rep.status = batch_status;
      expected_replies.push_back(rep);
      open = 1'b0;
      batch_ids.delete();
    endfunction

    // Compare one accepted output beat with the oldest owed reply
    function void check_result(logic [2:0] st, logic pr, logic [7:0] k, logic [7:0] m);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: status %0d present %0b kernel %0d module %0d",
                 $time, st, pr, k, m);
        fails++;
        return;
      end
      want = expected_replies.pop_front();
      if (want.status !== st) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
        fails++;
      end
      if (want.present !== pr) begin
        $display("%0t: present expected %0b actual %0b", $time, want.present, pr);
        fails++;
      end
      if (want.kernel !== k) begin
        $display("%0t: kernel expected %0d actual %0d", $time, want.kernel, k);
        fails++;
      end
      if (want.mod_id !== m) begin
        $display("%0t: module expected %0d actual %0d", $time, want.mod_id, m);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function int count_owned();
      int n;
      n = 0;
      foreach (owned[i]) if (owned[i]) n++;
      return n;
    endfunction

    function int pick_free();
      int cand [$];
      foreach (owned[i]) if (!owned[i]) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction

    // Pick an owned service, of the given provider unless any owner will do
    function int pick_owned(bit [7:0] k, bit [7:0] m, bit any_owner);
      int cand [$];
      foreach (owned[i]) begin
        if (owned[i] && (any_owner || (owner_kernel[i] == k && owner_module[i] == m))) begin
          cand.push_back(i);
        end
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(cand.size() - 1)];
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] in_command_i;
  logic [7:0] in_service_id_i;
  logic [7:0] in_kernel_id_i;
  logic [7:0] in_module_id_i;
  logic       in_last_i;
  logic       in_no_ids_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] out_status_o;
  logic       out_provider_present_o;
  logic [7:0] out_provider_kernel_o;
  logic [7:0] out_provider_module_o;

  provider_checker sb;
  int unsigned     items_sent;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     stuck_cycles;

  wire in_beat  = in_valid_i && !in_stall_o;
  wire out_beat = out_valid_o && !out_stall_i;

  service_provider_table dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_command_i           (in_command_i),
    .in_service_id_i        (in_service_id_i),
    .in_kernel_id_i         (in_kernel_id_i),
    .in_module_id_i         (in_module_id_i),
    .in_last_i              (in_last_i),
    .in_no_ids_i            (in_no_ids_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_status_o           (out_status_o),
    .out_provider_present_o (out_provider_present_o),
    .out_provider_kernel_o  (out_provider_kernel_o),
    .out_provider_module_o  (out_provider_module_o)
  );

  always #5 clk_i = ~clk_i;

  // Drive receiver stall at random on each falling edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check every accepted output beat
  always @(posedge clk_i) begin
    if (rst_ni && out_beat) begin
      sb.check_result(out_status_o, out_provider_present_o, out_provider_kernel_o,
                      out_provider_module_o);
    end
  end

  // Abort when neither channel moves a beat for too long
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if (in_beat || out_beat) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("service_provider_table_tb NOT OK");
    $finish;
  end

  // Present one input beat after random idle cycles; hold it until accepted
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] sid,
                           input logic [7:0] kid, input logic [7:0] mid,
                           input logic last, input logic no_ids);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_command_i    <= cmd;
    in_service_id_i <= sid;
    in_kernel_id_i  <= kid;
    in_module_id_i  <= mid;
    in_last_i       <= last;
    in_no_ids_i     <= no_ids;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(cmd_e'(cmd), sid, kid, mid, last, no_ids);
    if (cmd != CMD_NONE) items_sent++;
  endtask

  // Drop valid and hold off until every owed reply has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_lookup();
    logic [7:0] sid;
    sid = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(SERVICES - 1));
    send_item(CMD_LOOKUP, sid, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic run_noise();
    send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Build one batch from the live table: free ids to register, owned ids to drop
  task automatic run_batch();
    logic [1:0] op;
    logic [1:0] item_op;
    logic [7:0] kid;
    logic [7:0] mid;
    logic [7:0] sid;
    int         len;
    int         pick;
    int         owned_n;
    owned_n = sb.count_owned();
    if (owned_n == 0) op = CMD_REG;
    else if (owned_n > 40) op = CMD_UNREG;
    else op = $urandom_range(1) ? CMD_UNREG : CMD_REG;
    if (op == CMD_UNREG) begin
      pick = sb.pick_owned(8'd0, 8'd0, 1'b1);
      kid  = sb.owner_kernel[pick];
      mid  = sb.owner_module[pick];
    end else begin
      kid = 8'($urandom_range(KERNELS - 1));
      mid = ($urandom_range(3) == 0) ? 8'(MODULES - 1) : 8'($urandom_range(MODULES - 1));
    end
    if ($urandom_range(9) == 0) kid = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) mid = 8'($urandom_range(255));
    case ($urandom_range(19))
      0: len = MAX_BATCH + 1;
      1: len = MAX_BATCH;
      2: len = 0;
      default: len = $urandom_range(1, 5);
    endcase
    // Empty batch: provider only
    if (len == 0) begin
      send_item(op, 8'($urandom_range(255)), kid, mid, 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      item_op = ($urandom_range(19) == 0) ? (op ^ 2'd1) : op;
      if (item_op == CMD_REG) pick = sb.pick_free();
      else pick = sb.pick_owned(kid, mid, 1'b0);
      if (pick < 0 || $urandom_range(11) == 0) sid = 8'($urandom_range(255));
      else sid = 8'(pick);
      if ($urandom_range(7) == 0) run_lookup();
      if ($urandom_range(29) == 0) begin
        send_item(CMD_NONE, sid, kid, mid, 1'($urandom_range(1)), 1'b0);
      end
      send_item(item_op, sid,
                (i == 0) ? kid : 8'($urandom_range(255)),
                (i == 0) ? mid : 8'($urandom_range(255)),
                (i == len - 1), (i != len - 1) && ($urandom_range(14) == 0));
    end
  endtask

  // Short walk: every status but ST_TOO_LONG, empty, mixed, interleaved batches
  task automatic run_directed();
    send_item(CMD_LOOKUP, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(CMD_LOOKUP, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    send_item(CMD_LOOKUP, 8'(SERVICES), 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(CMD_REG, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(CMD_REG, 8'd1, 8'd255, 8'd255, 1'b1, 1'b0);
    send_item(CMD_LOOKUP, 8'd1, 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(CMD_REG, 8'(SERVICES - 1), 8'(KERNELS - 1), 8'(MODULES - 1), 1'b1, 1'b0);
    send_item(CMD_LOOKUP, 8'(SERVICES - 1), 8'd0, 8'd0, 1'b0, 1'b0);
    // Provider range: kernel ahead of module
    send_item(CMD_REG, 8'd5, 8'(KERNELS), 8'd0, 1'b1, 1'b0);
    send_item(CMD_REG, 8'd5, 8'd255, 8'd255, 1'b1, 1'b0);
    send_item(CMD_REG, 8'd5, 8'd1, 8'(MODULES), 1'b1, 1'b0);
    send_item(CMD_REG, 8'(SERVICES), 8'd1, 8'd1, 1'b1, 1'b0);
    // Taken id after a good one: nothing commits
    send_item(CMD_REG, 8'd7, 8'd1, 8'd1, 1'b0, 1'b0);
    send_item(CMD_REG, 8'd0, 8'd1, 8'd1, 1'b1, 1'b0);
    send_item(CMD_LOOKUP, 8'd7, 8'd0, 8'd0, 1'b0, 1'b0);
    // Not owner: other provider, and no provider at all
    send_item(CMD_UNREG, 8'd0, 8'd1, 8'd1, 1'b1, 1'b0);
    send_item(CMD_UNREG, 8'd2, 8'd0, 8'd0, 1'b1, 1'b0);
    // Empty batches
    send_item(CMD_REG, 8'd9, 8'd2, 8'd3, 1'b1, 1'b1);
    send_item(CMD_REG, 8'd9, 8'd3, 8'(MODULES), 1'b1, 1'b1);
    // Mixed batch with a lookup and an unknown command inside
    send_item(CMD_REG, 8'd21, 8'd2, 8'd7, 1'b1, 1'b0);
    send_item(CMD_REG, 8'd20, 8'd2, 8'd7, 1'b0, 1'b0);
    send_item(CMD_LOOKUP, 8'd21, 8'd0, 8'd0, 1'b0, 1'b0);
    send_item(CMD_NONE, 8'd21, 8'd0, 8'd0, 1'b1, 1'b0);
    send_item(CMD_UNREG, 8'd21, 8'd0, 8'd0, 1'b1, 1'b0);
    send_item(CMD_LOOKUP, 8'd21, 8'd0, 8'd0, 1'b0, 1'b0);
    // Duplicate id within one batch passes
    send_item(CMD_REG, 8'd30, 8'd1, 8'd2, 1'b0, 1'b0);
    send_item(CMD_REG, 8'd30, 8'd1, 8'd2, 1'b1, 1'b0);
  endtask

  // Main sequence: reset, directed run, four idling phases, final check
  initial begin
    int unsigned send_pct [4];
    int unsigned recv_pct [4];
    int unsigned target;
    int unsigned roll;
    send_pct = '{0, 72, 0, 38};
    recv_pct = '{0, 0, 72, 38};
    sb              = new();
    items_sent      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_command_i    = CMD_LOOKUP;
    in_service_id_i = 8'd0;
    in_kernel_id_i  = 8'd0;
    in_module_id_i  = 8'd0;
    in_last_i       = 1'b0;
    in_no_ids_i     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        roll = $urandom_range(99);
        if (roll < 45) run_lookup();
        else if (roll < 90) run_batch();
        else run_noise();
      end
      wait_drained();
    end

    repeat (END_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("service_provider_table_tb OK");
    end else begin
      $display("service_provider_table_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/spt_pkg.sv
rtl/core/spt_ram.sv
rtl/core/spt_check.sv
rtl/core/service_provider_table.sv
tb/service_provider_table_tb.sv
